FILE: sv/rclr_pkg.sv
package rclr_pkg;

  // fixed field widths
  localparam int KEY_IN_W   = 20;
  localparam int VAL_W      = 31;
  localparam int CAP_W      = 5;
  localparam int POL_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int LFSR_W     = 16;

  // lfsr seed and galois feedback mask
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // register reset values
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // replacement policy codes (any other code behaves as lru)
  localparam logic [POL_W-1:0] POL_LRU    = 2'd0;
  localparam logic [POL_W-1:0] POL_RANDOM = 2'd1;

  // command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_DIV,
    ST_EVICT,
    ST_INSERT,
    ST_READ,
    ST_RESULT
  } state_t;

  // operation broadcast to every entry lane
  typedef enum logic [1:0] {
    LANE_NONE,
    LANE_PROMOTE,
    LANE_EVICT,
    LANE_INSERT
  } lane_op_t;

  // one galois lfsr step
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] n;
    n = s >> 1;
    if (s[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

endpackage

FILE: sv/rclr_mod_unit.sv
module rclr_mod_unit #(
  parameter int DIV_W = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rclr_pkg::LFSR_W-1:0] dividend,
  input  logic [DIV_W-1:0]           divisor,
  output logic                       done,
  output logic [DIV_W-1:0]           rem
);
  import rclr_pkg::*;

  localparam int CNT_W = $clog2(LFSR_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(LFSR_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LFSR_W-1:0] dvd_r;
  logic [DIV_W-1:0]  dsr_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W-1:0]  rem_nxt;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dvd_r[LFSR_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = DIV_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = DIV_W'(trial);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: sv/rclr_value_ram.sv
module rclr_value_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [rclr_pkg::VAL_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [rclr_pkg::VAL_W-1:0] rdata
);
  import rclr_pkg::*;

  logic [VAL_W-1:0] mem_r [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/replacement_cache_lru_random.sv
// Fully associative key/value cache with lru or random replacement.
// Input channel: in_valid/in_stall with in_cmd (0 get, 1 put), in_lookup_key
// and in_store_value. One item is worked at a time; in_stall is high from
// acceptance until the result is written to the output register.
// Output channel: out_valid/out_stall with out_hit and out_read_value, one
// result per item. The output register lets a new item be accepted while a
// result still waits; a stalled result holds until taken, and the sequencer
// waits in its last step only if the register is still full.
// Steps per item: idle, lookup, decide, then result for a get miss or put
// hit, read then result for a get hit, insert then result for a put without
// eviction, and evict, insert, result for a put with lru eviction; a put with
// random eviction first waits in div for the 16-step restoring modulo unit
// that reduces the lfsr by the entry count. out_valid rises in the same cycle
// that the next item can be taken. Keys are compared in parallel lanes; values
// sit in a one-port-write, one-port-read ram with registered read data.
// Configuration: cfg_valid/cfg_ready (always ready), index 0 capacity in use,
// index 1 replacement policy; write only while the block is idle.
// Reset (synchronous, active low) clears all valid bits, ranks and the count
// at once and reloads the lfsr seed; there is no clearing pass.
module replacement_cache_lru_random #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_cmd,
  input  logic [rclr_pkg::KEY_IN_W-1:0]   in_lookup_key,
  input  logic [rclr_pkg::VAL_W-1:0]      in_store_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [rclr_pkg::VAL_W-1:0]      out_read_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rclr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rclr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rclr_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int RW = SW;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  state_t state_r, state_nxt;
  lane_op_t lane_op;

  logic [CAP_W-1:0]     cap_r;
  logic [POL_W-1:0]     pol_r;
  logic                 cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [VAL_W-1:0]     val_r;
  logic                 hit_r;
  logic [SW-1:0]        slot_r;
  logic [RW-1:0]        hrank_r;
  logic [RW-1:0]        victim_r;
  logic                 res_hit_r;
  logic [VAL_W-1:0]     res_val_r;
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [VAL_W-1:0]     out_val_r;
  logic [LFSR_W-1:0]    lfsr_r;
  logic [CW-1:0]        count_r;
  logic [CAPACITY-1:0]  valid_r;
  logic [RW-1:0]        rank_r [CAPACITY];
  logic [KEY_WIDTH-1:0] key_mem_r [CAPACITY];

  logic [KEY_WIDTH-1:0] key_sat;
  logic [CAPACITY-1:0]  match;
  logic                 hit_any;
  logic [SW-1:0]        hit_idx;
  logic [RW-1:0]        hit_rank;
  logic                 free_any;
  logic [SW-1:0]        free_idx;
  logic [EW-1:0]        cap_ext;
  logic [EW-1:0]        eff_cap;
  logic                 need_evict;
  logic                 is_rand;
  logic                 out_load;

  logic                 ram_we;
  logic [SW-1:0]        ram_waddr;
  logic                 ram_re;
  logic [VAL_W-1:0]     ram_rdata;
  logic                 div_start;
  logic                 div_done;
  logic [CW-1:0]        div_rem;
  logic                 lfsr_adv;
  logic [LFSR_W-1:0]    lfsr_next;

  // key saturation to the stored key width
  always_comb begin
    if (KEY_WIDTH >= KEY_IN_W) begin
      key_sat = KEY_WIDTH'(in_lookup_key);
    end else if ((in_lookup_key >> KEY_WIDTH) != '0) begin
      key_sat = '1;
    end else begin
      key_sat = KEY_WIDTH'(in_lookup_key);
    end
  end

  // parallel key compare, hit slot and its rank
  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = valid_r[i] && (key_mem_r[i] == key_r);
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = SW'(i);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) hit_rank = hit_rank | rank_r[i];
    end
  end
  assign hit_any = |match;

  // first free slot
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = SW'(i);
    end
  end
  assign free_any = ~&valid_r;

  // effective capacity and eviction decision
  assign cap_ext = EW'(cap_r);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(CAPACITY)) begin
      eff_cap = EW'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign need_evict = (EW'(count_r) >= eff_cap) && (count_r != '0);
  assign is_rand    = (pol_r == POL_RANDOM);
  assign out_load   = (state_r == ST_RESULT) && (!out_valid_r || !out_stall);
  assign lfsr_next  = lfsr_step(lfsr_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (cmd_r == CMD_GET) begin
          state_nxt = hit_r ? ST_READ : ST_RESULT;
        end else if (hit_r) begin
          state_nxt = ST_RESULT;
        end else if (need_evict) begin
          state_nxt = is_rand ? ST_DIV : ST_EVICT;
        end else begin
          state_nxt = ST_INSERT;
        end
      end
      ST_DIV:    if (div_done) state_nxt = ST_EVICT;
      ST_EVICT:  state_nxt = ST_INSERT;
      ST_INSERT: state_nxt = ST_RESULT;
      ST_READ:   state_nxt = ST_RESULT;
      ST_RESULT: if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    lane_op   = LANE_NONE;
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_re    = 1'b0;
    div_start = 1'b0;
    lfsr_adv  = 1'b0;
    case (state_r)
      ST_DECIDE: begin
        if (hit_r && (cmd_r == CMD_PUT || !is_rand)) lane_op = LANE_PROMOTE;
        if (hit_r && cmd_r == CMD_GET) ram_re = 1'b1;
        if (hit_r && cmd_r == CMD_PUT) ram_we = 1'b1;
        if (!hit_r && cmd_r == CMD_PUT && need_evict && is_rand) begin
          lfsr_adv  = 1'b1;
          div_start = 1'b1;
        end
      end
      ST_EVICT: lane_op = LANE_EVICT;
      ST_INSERT: begin
        if (free_any) begin
          lane_op   = LANE_INSERT;
          ram_we    = 1'b1;
          ram_waddr = free_idx;
        end
      end
      default: lane_op = LANE_NONE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lfsr_r      <= LFSR_SEED;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      pol_r       <= POL_LRU;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (lfsr_adv) lfsr_r <= lfsr_next;
      if (lane_op == LANE_EVICT) begin
        count_r <= count_r - 1'b1;
      end else if (lane_op == LANE_INSERT) begin
        count_r <= count_r + 1'b1;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CAPACITY: cap_r <= cfg_data;
          CFG_POLICY:   pol_r <= cfg_data[POL_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  // item capture, lookup result and result registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r <= in_cmd;
      key_r <= key_sat;
      val_r <= in_store_value;
    end
    if (state_r == ST_LOOKUP) begin
      hit_r   <= hit_any;
      slot_r  <= hit_idx;
      hrank_r <= hit_rank;
    end
    if (state_r == ST_DECIDE) begin
      victim_r  <= RW'(count_r - 1'b1);
      res_hit_r <= hit_r && (cmd_r == CMD_GET);
      res_val_r <= '0;
    end
    if (state_r == ST_DIV && div_done) victim_r <= div_rem[RW-1:0];
    if (state_r == ST_READ) res_val_r <= ram_rdata;
    if (out_load) begin
      out_hit_r <= res_hit_r;
      out_val_r <= res_val_r;
    end
  end

  // entry lanes: valid bits and recency ranks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < CAPACITY; i++) rank_r[i] <= '0;
    end else begin
      for (int i = 0; i < CAPACITY; i++) begin
        case (lane_op)
          LANE_PROMOTE: begin
            if (SW'(i) == slot_r) begin
              rank_r[i] <= '0;
            end else if (valid_r[i] && rank_r[i] < hrank_r) begin
              rank_r[i] <= rank_r[i] + 1'b1;
            end
          end
          LANE_EVICT: begin
            if (valid_r[i] && rank_r[i] == victim_r) begin
              valid_r[i] <= 1'b0;
              rank_r[i]  <= '0;
            end else if (valid_r[i] && rank_r[i] > victim_r) begin
              rank_r[i] <= rank_r[i] - 1'b1;
            end
          end
          LANE_INSERT: begin
            if (SW'(i) == free_idx) begin
              valid_r[i] <= 1'b1;
              rank_r[i]  <= '0;
            end else if (valid_r[i]) begin
              rank_r[i] <= rank_r[i] + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // stored keys
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (lane_op == LANE_INSERT && SW'(i) == free_idx) key_mem_r[i] <= key_r;
    end
  end

  rclr_value_ram #(
    .DEPTH (CAPACITY),
    .AW    (SW)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  rclr_mod_unit #(
    .DIV_W (CW)
  ) u_mod_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lfsr_next),
    .divisor  (count_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_val_r;
  assign cfg_ready      = 1'b1;

  // fill count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CW'($countones(valid_r)))
    else $error("entry count differs from number of valid entries");

  // keys are unique, so a lookup matches at most one lane
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |-> $onehot0(match))
    else $error("key present in more than one entry");

  // the victim rank always names a live entry
  a_victim_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVICT) |-> (CW'(victim_r) < count_r))
    else $error("victim rank beyond entry count");

  // an insert always finds a free slot
  a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT) |-> free_any)
    else $error("insert with no free entry");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rclr_pkg::*;

  localparam int CACHE_SLOTS = 16;
  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASE_ITEMS = 92;

  // directed plan rows: either one item or a pair of register writes
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               cmd;
    logic [KEY_IN_W-1:0] key;
    logic [VAL_W-1:0]   val;
    logic               typed;
    logic               hit;
    logic [VAL_W-1:0]   rv;
    logic [CAP_W-1:0]   cap;
    logic [POL_W-1:0]   pol;
  } plan_row_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] rv;
  } cache_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_cmd;
  logic [KEY_IN_W-1:0]   in_lookup_key;
  logic [VAL_W-1:0]      in_store_value;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_hit;
  logic [VAL_W-1:0]      out_read_value;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  replacement_cache_lru_random dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_lookup_key  (in_lookup_key),
    .in_store_value (in_store_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // shadow copy of the cache contents and registers
  logic [KEY_IN_W-1:0] shadow_key  [CACHE_SLOTS];
  logic [VAL_W-1:0]    shadow_val  [CACHE_SLOTS];
  logic                shadow_live [CACHE_SLOTS];
  int                  shadow_rank [CACHE_SLOTS];
  int                  shadow_count;
  logic [LFSR_W-1:0]   shadow_lfsr;
  logic [CAP_W-1:0]    shadow_cap;
  logic [POL_W-1:0]    shadow_pol;

  cache_result_t pending_results[$];
  cache_result_t got_exp;
  plan_row_t     plan[$];

  // per-item override when the directed row carries its own answer
  logic             typed_on;
  logic             typed_hit;
  logic [VAL_W-1:0] typed_rv;

  int error_count = 0;
  int idle_cycles = 0;
  int stall_mode;
  int stall_tick = 0;

  logic [KEY_IN_W-1:0] key_pool [64];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // move one slot to the front; more recent entries age by one
  task automatic promote_slot(input int s);
    int r;
    r = shadow_rank[s];
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (shadow_live[i] && shadow_rank[i] < r) shadow_rank[i]++;
    shadow_rank[s] = 0;
  endtask

  // drop one entry: least recent, or the lfsr-chosen rank under random policy
  task automatic evict_victim();
    int victim;
    logic [LFSR_W-1:0] nxt;
    if (shadow_count == 0) return;
    if (shadow_pol == POL_RANDOM) begin
      nxt = {1'b0, shadow_lfsr[LFSR_W-1:1]};
      if (shadow_lfsr[0]) nxt = nxt ^ LFSR_TAPS;
      shadow_lfsr = nxt;
      victim = int'(shadow_lfsr) % shadow_count;
    end else begin
      victim = shadow_count - 1;
    end
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (shadow_live[i] && shadow_rank[i] == victim) begin
        shadow_live[i] = 1'b0;
        shadow_rank[i] = 0;
      end
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (shadow_live[i] && shadow_rank[i] > victim) shadow_rank[i]--;
    shadow_count--;
  endtask

  // apply one get or put to the shadow cache and produce its answer
  task automatic cache_access(input logic cmd, input logic [KEY_IN_W-1:0] key,
                              input logic [VAL_W-1:0] val, output cache_result_t res);
    int slot;
    int free_slot;
    int eff_cap;
    slot = -1;
    res = '0;
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (slot < 0 && shadow_live[i] && shadow_key[i] == key) slot = i;
    if (cmd == CMD_GET) begin
      if (slot >= 0) begin
        res.hit = 1'b1;
        res.rv  = shadow_val[slot];
        if (shadow_pol != POL_RANDOM) promote_slot(slot);
      end
      return;
    end
    // put to a present key updates in place
    if (slot >= 0) begin
      shadow_val[slot] = val;
      promote_slot(slot);
      return;
    end
    eff_cap = (shadow_cap == 0) ? 1 : (shadow_cap > CACHE_SLOTS ? CACHE_SLOTS : shadow_cap);
    if (shadow_count >= eff_cap) evict_victim();
    free_slot = -1;
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (free_slot < 0 && !shadow_live[i]) free_slot = i;
    if (free_slot < 0) return;
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (shadow_live[i]) shadow_rank[i]++;
    shadow_key[free_slot]  = key;
    shadow_val[free_slot]  = val;
    shadow_live[free_slot] = 1'b1;
    shadow_rank[free_slot] = 0;
    shadow_count++;
  endtask

  // result check and prediction of accepted items
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no item waiting: hit %0d read_value %0h",
                 out_hit, out_read_value);
          error_count++;
        end else begin
          got_exp = pending_results.pop_front();
          if (out_hit !== got_exp.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", got_exp.hit, out_hit);
            error_count++;
          end
          if (out_read_value !== got_exp.rv) begin
            $error("read_value mismatch: expected %0h, actual %0h",
                   got_exp.rv, out_read_value);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        cache_access(in_cmd, in_lookup_key, in_store_value, got_exp);
        if (typed_on) begin
          got_exp.hit = typed_hit;
          got_exp.rv  = typed_rv;
        end
        pending_results.push_back(got_exp);
      end
    end
  end

  // watchdog: cycles with no item, result or register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver stall pattern, selected per phase
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      1: begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
      2: begin
        out_stall <= ((stall_tick % 16) >= 10);
      end
      3: begin
        out_stall <= ($urandom_range(0, 99) < 70);
      end
      default: begin
        out_stall <= 1'b0;
      end
    endcase
  end

  // present one item and hold it until accepted
  task automatic send_item(input logic cmd, input logic [KEY_IN_W-1:0] key,
                           input logic [VAL_W-1:0] val, input logic typed,
                           input logic hit, input logic [VAL_W-1:0] rv);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_lookup_key  <= key;
    in_store_value <= val;
    typed_on  = typed;
    typed_hit = hit;
    typed_rv  = rv;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic lower_valid();
    @(negedge clk);
    in_valid <= 1'b0;
    typed_on = 1'b0;
  endtask

  // wait until every item has answered
  task automatic drain_results();
    lower_valid();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write both registers while idle
  task automatic set_config(input logic [CAP_W-1:0] cap, input logic [POL_W-1:0] pol);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CAPACITY;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    shadow_cap = cap;
    @(negedge clk);
    cfg_index <= CFG_POLICY;
    cfg_data  <= CFG_DATA_W'(pol);
    do @(posedge clk); while (!cfg_ready);
    shadow_pol = pol;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t item_row(input logic cmd, input logic [KEY_IN_W-1:0] key,
                                         input logic [VAL_W-1:0] val, input logic typed,
                                         input logic hit, input logic [VAL_W-1:0] rv);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_ITEM;
    r.cmd   = cmd;
    r.key   = key;
    r.val   = val;
    r.typed = typed;
    r.hit   = hit;
    r.rv    = rv;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CAP_W-1:0] cap,
                                        input logic [POL_W-1:0] pol);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cap  = cap;
    r.pol  = pol;
    return r;
  endfunction

  initial begin
    plan_row_t row;
    int phase_cap  [12];
    int phase_pol  [12];
    int eff_cap;
    int pool_n;
    int burst_left;
    int gap;
    logic gaps_on;
    logic              cmd;
    logic [KEY_IN_W-1:0] key;
    logic [VAL_W-1:0]  val;

    in_valid       = 1'b0;
    in_cmd         = CMD_GET;
    in_lookup_key  = '0;
    in_store_value = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_CAPACITY;
    cfg_data       = '0;
    typed_on       = 1'b0;
    typed_hit      = 1'b0;
    typed_rv       = '0;
    stall_mode     = 0;

    // shadow state after reset
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
      shadow_live[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_count = 0;
    shadow_lfsr  = LFSR_SEED;
    shadow_cap   = CAP_RESET;
    shadow_pol   = POL_LRU;

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed plan: empty cache, key and value extremes, in-place update
    plan.push_back(item_row(CMD_GET, 20'h00000, 31'h0, 1'b1, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_PUT, 20'h00000, 31'h7FFFFFFF, 1'b1, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'h00000, 31'h0, 1'b1, 1'b1, 31'h7FFFFFFF));
    plan.push_back(item_row(CMD_PUT, 20'hFFFFF, 31'h0, 1'b1, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'hFFFFF, 31'h7FFFFFFF, 1'b1, 1'b1, 31'h0));
    plan.push_back(item_row(CMD_PUT, 20'h00000, 31'h12345678, 1'b1, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'h00000, 31'h0, 1'b1, 1'b1, 31'h12345678));
    // lru eviction at capacity two
    plan.push_back(cfg_row(5'd2, POL_LRU));
    plan.push_back(item_row(CMD_PUT, 20'h00005, 31'h55, 1'b1, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'hFFFFF, 31'h0, 1'b0, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'h00000, 31'h0, 1'b0, 1'b0, 31'h0));
    // capacity zero acts as one, and lies below the live count
    plan.push_back(cfg_row(5'd0, POL_LRU));
    plan.push_back(item_row(CMD_PUT, 20'h00007, 31'h77, 1'b1, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'h00005, 31'h0, 1'b0, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'h00007, 31'h0, 1'b0, 1'b0, 31'h0));
    // random eviction
    plan.push_back(cfg_row(5'd3, POL_RANDOM));
    plan.push_back(item_row(CMD_PUT, 20'h00010, 31'h0A0A0A0A, 1'b1, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_PUT, 20'h00011, 31'h0B0B0B0B, 1'b1, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_PUT, 20'h00012, 31'h0C0C0C0C, 1'b1, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_PUT, 20'h00013, 31'h0D0D0D0D, 1'b1, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'h00010, 31'h0, 1'b0, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'h00011, 31'h0, 1'b0, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'h00012, 31'h0, 1'b0, 1'b0, 31'h0));
    // policy code three and capacity above the slot count
    plan.push_back(cfg_row(5'd31, 2'd3));
    plan.push_back(item_row(CMD_PUT, 20'h00020, 31'h2020, 1'b1, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'h00013, 31'h0, 1'b0, 1'b0, 31'h0));
    // policy code two behaves as lru
    plan.push_back(cfg_row(5'd31, 2'd2));
    plan.push_back(item_row(CMD_GET, 20'h00020, 31'h0, 1'b0, 1'b0, 31'h0));
    plan.push_back(item_row(CMD_GET, 20'h00012, 31'h0, 1'b0, 1'b0, 31'h0));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        drain_results();
        set_config(row.cap, row.pol);
      end else begin
        send_item(row.cmd, row.key, row.val, row.typed, row.hit, row.rv);
      end
    end

    // random phases across capacities and policies
    phase_cap = '{16, 1, 31, 4, 0, 17, 2, 16, 8, 5, 12, 31};
    phase_pol = '{0, 1, 0, 1, 2, 1, 3, 1, 0, 1, 2, 1};
    for (int p = 0; p < 12; p++) begin
      drain_results();
      stall_mode = p % 4;
      set_config(CAP_W'(phase_cap[p]), POL_W'(phase_pol[p]));
      eff_cap = (phase_cap[p] == 0) ? 1 : (phase_cap[p] > CACHE_SLOTS ? CACHE_SLOTS
                                                                       : phase_cap[p]);
      pool_n = eff_cap + $urandom_range(1, eff_cap + 2);
      if (pool_n > 64) pool_n = 64;
      for (int k = 0; k < pool_n; k++) key_pool[k] = KEY_IN_W'($urandom);
      gaps_on    = (p % 3) != 2;
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // in phase three the sender pauses once mid-phase until everything has answered
        if (p == 3 && n == 40) begin
          drain_results();
        end
        if (gaps_on && burst_left == 0) begin
          lower_valid();
          gap = $urandom_range(1, 8);
          repeat (gap - 1) @(negedge clk);
          burst_left = $urandom_range(1, 24);
        end
        cmd = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
        if ($urandom_range(0, 99) < 85)
          key = key_pool[$urandom_range(0, pool_n - 1)];
        else
          key = KEY_IN_W'($urandom);
        val = VAL_W'($urandom);
        send_item(cmd, key, val, 1'b0, 1'b0, '0);
        burst_left--;
      end
    end

    // wind down: all results in, then a quiet wait for strays
    drain_results();
    stall_mode = 0;
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
